>>> rtl/btpc_pkg.sv
`timescale 1ns / 1ps
// btpc_pkg: request/response payload types, CSR index codes and fixed
// widths for the barometric compensation pipeline. No dependencies.
package btpc_pkg;

   localparam int RAW_W  = 24;
   localparam int CAL_W  = 16;
   localparam int TEMP_W = 15;
   localparam int PRES_W = 18;
   localparam int CSR_IDX_W = 3;

   localparam int DT_W    = 25;
   localparam int PTC_W   = 42;
   localparam int PDD_W   = 50;
   localparam int T1_W    = 20;
   localparam int T2_W    = 18;
   localparam int OFF1_W  = 36;
   localparam int SENS1_W = 35;
   localparam int SQ_W    = 36;
   localparam int CORR_W  = 40;
   localparam int OFSN_W  = 41;
   localparam int PLO_W   = 44;
   localparam int PHI_W   = 46;
   localparam int PSUM_W  = 66;
   localparam int PDIF_W  = 46;

   localparam logic signed [T1_W-1:0] TEMP_REF  = 20'sd2000;
   localparam logic signed [T1_W-1:0] TEMP_COLD = -20'sd1500;
   localparam logic signed [T1_W-1:0] TEMP_MIN  = -20'sd16384;
   localparam logic signed [T1_W-1:0] TEMP_MAX  = 20'sd16383;
   localparam logic signed [PDIF_W-1:0] PRES_MAX = 46'sd262143;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SENS    = 3'd0,
      CSR_OFF     = 3'd1,
      CSR_TCS     = 3'd2,
      CSR_TCO     = 3'd3,
      CSR_TREF    = 3'd4,
      CSR_TEMPSENS = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [RAW_W-1:0] raw_pressure;
      logic [RAW_W-1:0] raw_temperature;
   } req_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature;
      logic [PRES_W-1:0]        pressure;
      logic                     saturated;
   } rsp_type;

endpackage

>>> rtl/baro_temp_pressure_compensation_top.sv
`timescale 1ns / 1ps
// Barometric temperature/pressure compensation with second-order correction.
// Depends on btpc_pkg.
// Pipeline: 9 register stages from request accept to response valid.
// Throughput: one request per cycle; a stalled response only holds stages
// that are full, bubbles ahead of it still fill.
// Reset (synchronous): clears all stage valid bits and the six calibration
// words to zero.
module baro_temp_pressure_compensation_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  btpc_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output btpc_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [btpc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [btpc_pkg::CAL_W-1:0]        csr_wdata
);

   localparam int NUM_STAGES = 9;

   logic [btpc_pkg::CAL_W-1:0] sens_ff, off_ff, tcs_ff, tco_ff, tref_ff, tc_ff;

   logic [NUM_STAGES:1] valid_ff;
   logic [NUM_STAGES:1] en;
   logic [NUM_STAGES:1] valid_prev;

   // stage 1
   logic [btpc_pkg::RAW_W-1:0]        s1_d1_ff;
   logic signed [btpc_pkg::DT_W-1:0]  s1_dt_in, s1_dt_ff;
   // stage 2
   logic [btpc_pkg::RAW_W-1:0]        s2_d1_ff;
   logic signed [btpc_pkg::PTC_W-1:0] s2_tc_in, s2_tc_ff, s2_tco_in, s2_tco_ff;
   logic signed [btpc_pkg::PTC_W-1:0] s2_tcs_in, s2_tcs_ff;
   logic signed [btpc_pkg::PDD_W-1:0] s2_dd_in, s2_dd_ff;
   // stage 3
   logic [btpc_pkg::RAW_W-1:0]          s3_d1_ff;
   logic signed [btpc_pkg::T1_W-1:0]    s3_temp_in, s3_temp_ff;
   logic signed [btpc_pkg::T1_W-1:0]    s3_dm_in, s3_dm_ff, s3_dp_in, s3_dp_ff;
   logic [btpc_pkg::T2_W-1:0]           s3_t2_in, s3_t2_ff;
   logic signed [btpc_pkg::OFF1_W-1:0]  s3_off_in, s3_off_ff;
   logic signed [btpc_pkg::SENS1_W-1:0] s3_sens_in, s3_sens_ff;
   logic                                warm_lo, cold_lo;
   // stage 4
   logic [btpc_pkg::RAW_W-1:0]          s4_d1_ff;
   logic signed [btpc_pkg::T1_W-1:0]    s4_temp_ff;
   logic [btpc_pkg::T2_W-1:0]           s4_t2_ff;
   logic signed [btpc_pkg::OFF1_W-1:0]  s4_off_ff;
   logic signed [btpc_pkg::SENS1_W-1:0] s4_sens_ff;
   logic signed [2*btpc_pkg::T1_W-1:0]  sq_a, sq_b;
   logic [btpc_pkg::SQ_W-1:0]           s4_a_ff, s4_b_ff;
   // stage 5
   logic [btpc_pkg::RAW_W-1:0]          s5_d1_ff;
   logic signed [btpc_pkg::OFF1_W-1:0]  s5_off_ff;
   logic signed [btpc_pkg::SENS1_W-1:0] s5_sens_ff;
   logic [btpc_pkg::CORR_W-1:0]         a_x, b_x, five_a, seven_b, eleven_b;
   logic [btpc_pkg::CORR_W-1:0]         s5_off2_in, s5_off2_ff, s5_sens2_in, s5_sens2_ff;
   logic signed [btpc_pkg::T1_W-1:0]    temp_fin;
   logic signed [btpc_pkg::TEMP_W-1:0]  s5_tout_in, s5_tout_ff;
   logic                                s5_tsat_in, s5_tsat_ff;
   // stage 6
   logic [btpc_pkg::RAW_W-1:0]          s6_d1_ff;
   logic signed [btpc_pkg::OFSN_W-1:0]  s6_off_in, s6_off_ff, s6_sens_in, s6_sens_ff;
   logic signed [btpc_pkg::TEMP_W-1:0]  s6_tout_ff;
   logic                                s6_tsat_ff;
   // stage 7
   logic [btpc_pkg::PLO_W-1:0]          s7_lo_in, s7_lo_ff;
   logic signed [btpc_pkg::PHI_W-1:0]   s7_hi_in, s7_hi_ff;
   logic signed [btpc_pkg::OFSN_W-1:0]  s7_off_ff;
   logic signed [btpc_pkg::TEMP_W-1:0]  s7_tout_ff;
   logic                                s7_tsat_ff;
   // stage 8
   logic signed [btpc_pkg::PSUM_W-1:0]  s8_psum_in, s8_psum_ff;
   logic signed [btpc_pkg::OFSN_W-1:0]  s8_off_ff;
   logic signed [btpc_pkg::TEMP_W-1:0]  s8_tout_ff;
   logic                                s8_tsat_ff;
   // stage 9 (output)
   logic signed [btpc_pkg::PDIF_W-1:0]  pdiff, pres_c;
   btpc_pkg::rsp_type                   rsp_in, rsp_ff;

   // calibration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff <= '0;
         off_ff  <= '0;
         tcs_ff  <= '0;
         tco_ff  <= '0;
         tref_ff <= '0;
         tc_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            btpc_pkg::CSR_SENS:     sens_ff <= csr_wdata;
            btpc_pkg::CSR_OFF:      off_ff  <= csr_wdata;
            btpc_pkg::CSR_TCS:      tcs_ff  <= csr_wdata;
            btpc_pkg::CSR_TCO:      tco_ff  <= csr_wdata;
            btpc_pkg::CSR_TREF:     tref_ff <= csr_wdata;
            btpc_pkg::CSR_TEMPSENS: tc_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline flow control
   always_comb begin
      en[NUM_STAGES] = !valid_ff[NUM_STAGES] || !rsp_stall;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign valid_prev = {valid_ff[NUM_STAGES-1:1], req_valid};
   assign req_stall  = !en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= NUM_STAGES; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_prev[k];
            end
         end
      end
   end

   // datapath
   always_comb begin
      s1_dt_in = $signed({1'b0, req_data.raw_temperature}) - $signed({1'b0, tref_ff, 8'b0});

      s2_tc_in  = s1_dt_ff * $signed({1'b0, tc_ff});
      s2_tco_in = s1_dt_ff * $signed({1'b0, tco_ff});
      s2_tcs_in = s1_dt_ff * $signed({1'b0, tcs_ff});
      s2_dd_in  = s1_dt_ff * s1_dt_ff;

      s3_temp_in = btpc_pkg::T1_W'(s2_tc_ff >>> 23) + btpc_pkg::TEMP_REF;
      warm_lo    = s3_temp_in < btpc_pkg::TEMP_REF;
      cold_lo    = s3_temp_in < btpc_pkg::TEMP_COLD;
      s3_dm_in   = warm_lo ? s3_temp_in - btpc_pkg::TEMP_REF : '0;
      s3_dp_in   = cold_lo ? s3_temp_in - btpc_pkg::TEMP_COLD : '0;
      s3_t2_in   = warm_lo ? btpc_pkg::T2_W'(s2_dd_ff >>> 31) : '0;
      s3_off_in  = $signed({4'b0, off_ff, 16'b0}) + btpc_pkg::OFF1_W'(s2_tco_ff >>> 7);
      s3_sens_in = $signed({4'b0, sens_ff, 15'b0}) + btpc_pkg::SENS1_W'(s2_tcs_ff >>> 8);

      sq_a = s3_dm_ff * s3_dm_ff;
      sq_b = s3_dp_ff * s3_dp_ff;

      a_x      = {4'b0, s4_a_ff};
      b_x      = {4'b0, s4_b_ff};
      five_a   = a_x + {a_x[btpc_pkg::CORR_W-3:0], 2'b0};
      seven_b  = {b_x[btpc_pkg::CORR_W-4:0], 3'b0} - b_x;
      eleven_b = {b_x[btpc_pkg::CORR_W-4:0], 3'b0} + {b_x[btpc_pkg::CORR_W-2:0], 1'b0} + b_x;
      s5_off2_in  = (five_a >> 1) + seven_b;
      s5_sens2_in = (five_a >> 2) + (eleven_b >> 1);
      temp_fin    = s4_temp_ff - $signed({2'b0, s4_t2_ff});
      if (temp_fin < btpc_pkg::TEMP_MIN) begin
         s5_tout_in = btpc_pkg::TEMP_W'(btpc_pkg::TEMP_MIN);
         s5_tsat_in = 1'b1;
      end else if (temp_fin > btpc_pkg::TEMP_MAX) begin
         s5_tout_in = btpc_pkg::TEMP_W'(btpc_pkg::TEMP_MAX);
         s5_tsat_in = 1'b1;
      end else begin
         s5_tout_in = temp_fin[btpc_pkg::TEMP_W-1:0];
         s5_tsat_in = 1'b0;
      end

      s6_off_in  = btpc_pkg::OFSN_W'(s5_off_ff) - $signed({1'b0, s5_off2_ff});
      s6_sens_in = btpc_pkg::OFSN_W'(s5_sens_ff) - $signed({1'b0, s5_sens2_ff});

      s7_lo_in = s6_d1_ff * s6_sens_ff[19:0];
      s7_hi_in = $signed({1'b0, s6_d1_ff}) * $signed(s6_sens_ff[btpc_pkg::OFSN_W-1:20]);

      s8_psum_in = $signed({s7_hi_ff, 20'b0}) + $signed({22'b0, s7_lo_ff});

      pdiff  = btpc_pkg::PDIF_W'(s8_psum_ff >>> 21) - btpc_pkg::PDIF_W'(s8_off_ff);
      pres_c = pdiff >>> 15;
      rsp_in.temperature = s8_tout_ff;
      if (pres_c < 0) begin
         rsp_in.pressure  = '0;
         rsp_in.saturated = 1'b1;
      end else if (pres_c > btpc_pkg::PRES_MAX) begin
         rsp_in.pressure  = '1;
         rsp_in.saturated = 1'b1;
      end else begin
         rsp_in.pressure  = pres_c[btpc_pkg::PRES_W-1:0];
         rsp_in.saturated = s8_tsat_ff;
      end
      if (s8_tsat_ff) begin
         rsp_in.saturated = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_d1_ff <= req_data.raw_pressure;
         s1_dt_ff <= s1_dt_in;
      end
      if (en[2]) begin
         s2_d1_ff  <= s1_d1_ff;
         s2_tc_ff  <= s2_tc_in;
         s2_tco_ff <= s2_tco_in;
         s2_tcs_ff <= s2_tcs_in;
         s2_dd_ff  <= s2_dd_in;
      end
      if (en[3]) begin
         s3_d1_ff   <= s2_d1_ff;
         s3_temp_ff <= s3_temp_in;
         s3_dm_ff   <= s3_dm_in;
         s3_dp_ff   <= s3_dp_in;
         s3_t2_ff   <= s3_t2_in;
         s3_off_ff  <= s3_off_in;
         s3_sens_ff <= s3_sens_in;
      end
      if (en[4]) begin
         s4_d1_ff   <= s3_d1_ff;
         s4_temp_ff <= s3_temp_ff;
         s4_t2_ff   <= s3_t2_ff;
         s4_off_ff  <= s3_off_ff;
         s4_sens_ff <= s3_sens_ff;
         s4_a_ff    <= sq_a[btpc_pkg::SQ_W-1:0];
         s4_b_ff    <= sq_b[btpc_pkg::SQ_W-1:0];
      end
      if (en[5]) begin
         s5_d1_ff    <= s4_d1_ff;
         s5_off_ff   <= s4_off_ff;
         s5_sens_ff  <= s4_sens_ff;
         s5_off2_ff  <= s5_off2_in;
         s5_sens2_ff <= s5_sens2_in;
         s5_tout_ff  <= s5_tout_in;
         s5_tsat_ff  <= s5_tsat_in;
      end
      if (en[6]) begin
         s6_d1_ff   <= s5_d1_ff;
         s6_off_ff  <= s6_off_in;
         s6_sens_ff <= s6_sens_in;
         s6_tout_ff <= s5_tout_ff;
         s6_tsat_ff <= s5_tsat_ff;
      end
      if (en[7]) begin
         s7_lo_ff   <= s7_lo_in;
         s7_hi_ff   <= s7_hi_in;
         s7_off_ff  <= s6_off_ff;
         s7_tout_ff <= s6_tout_ff;
         s7_tsat_ff <= s6_tsat_ff;
      end
      if (en[8]) begin
         s8_psum_ff <= s8_psum_in;
         s8_off_ff  <= s7_off_ff;
         s8_tout_ff <= s7_tout_ff;
         s8_tsat_ff <= s7_tsat_ff;
      end
      if (en[9]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff[NUM_STAGES];
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/btpc_checker.sv
`timescale 1ns / 1ps
// btpc_checker: port-level assertions for the compensation top level,
// bound to it below. Depends on btpc_pkg.
module btpc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input btpc_pkg::rsp_type rsp_data,
   input logic              csr_valid,
   input logic              csr_ready
);

   // held response stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // pipeline drained after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a free output never backs up the request side
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("request stalled with free output");

   // an accepted request reaches the output while the output does not stall
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_stall) ##1 !rsp_stall ##1 !rsp_stall
      ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
      ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("response missing after request");

   // csr writes always taken
   assert property (@(posedge clock) disable iff (reset) csr_valid |-> csr_ready)
      else $error("csr write refused");

endmodule

bind baro_temp_pressure_compensation_top btpc_checker u_btpc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);
